// ===== design/utf16_to_koi8r_encoder_assert.svh =====
// Assertion macros shared by the UTF-16 to KOI8-R encoder RTL.
`ifndef UTF16_TO_KOI8R_ENCODER_ASSERT_SVH
`define UTF16_TO_KOI8R_ENCODER_ASSERT_SVH

// Same-cycle implication, checked only while the block is out of reset.
`define U2K_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while the block is out of reset.
`define U2K_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/u2k_pkg.sv =====
// Package with the KOI8-R lookup tables and the code unit conversion function.
`timescale 1ns / 1ps
`default_nettype none

package u2k_pkg;

    localparam int CODE_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int SYMBOL_COUNT = 64;
    localparam int LETTER_COUNT = 64;
    localparam int LETTER_IDX_W = $clog2(LETTER_COUNT);

    localparam logic [CODE_W-1:0] ASCII_LAST   = 16'h007F;
    localparam logic [CODE_W-1:0] LETTER_FIRST = 16'h0410;
    localparam logic [CODE_W-1:0] LETTER_LAST  = 16'h044F;
    localparam logic [BYTE_W-1:0] HIGH_BASE    = 8'h80;
    localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;

    localparam logic [BYTE_W-1:0] LETTER_MAP [LETTER_COUNT] = '{
        8'hE1, 8'hE2, 8'hF7, 8'hE7, 8'hE4, 8'hE5, 8'hF6, 8'hFA,
        8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF0,
        8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hE6, 8'hE8, 8'hE3, 8'hFE,
        8'hFB, 8'hFD, 8'hFF, 8'hF9, 8'hF8, 8'hFC, 8'hE0, 8'hF1,
        8'hC1, 8'hC2, 8'hD7, 8'hC7, 8'hC4, 8'hC5, 8'hD6, 8'hDA,
        8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0,
        8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hC6, 8'hC8, 8'hC3, 8'hDE,
        8'hDB, 8'hDD, 8'hDF, 8'hD9, 8'hD8, 8'hDC, 8'hC0, 8'hD1
    };

    // Entry i holds the code point that encodes as byte 0x80 + i.
    localparam logic [CODE_W-1:0] SYMBOL_POINTS [SYMBOL_COUNT] = '{
        16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
        16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
        16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
        16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
        16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
        16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
        16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
        16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9
    };

    // The symbol points are all distinct, so at most one compare hits and the
    // matching byte codes can simply be ORed together.
    function automatic logic [BYTE_W-1:0] to_koi8r(input logic [CODE_W-1:0] cu);
        logic [LETTER_IDX_W-1:0] letter_idx;
        logic [BYTE_W-1:0]       sym_byte;
        logic                    sym_hit;
        logic [BYTE_W-1:0]       result;
        letter_idx = cu[LETTER_IDX_W-1:0] - LETTER_FIRST[LETTER_IDX_W-1:0];
        sym_byte   = '0;
        sym_hit    = 1'b0;
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
            if (SYMBOL_POINTS[i] == cu) begin
                sym_hit  = 1'b1;
                sym_byte = sym_byte | (HIGH_BASE | BYTE_W'(i));
            end
        end
        if (cu <= ASCII_LAST) begin
            result = cu[BYTE_W-1:0];
        end else if (cu >= LETTER_FIRST && cu <= LETTER_LAST) begin
            result = LETTER_MAP[letter_idx];
        end else if (sym_hit) begin
            result = sym_byte;
        end else begin
            result = SPACE_BYTE;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== design/utf16_to_koi8r_encoder.sv =====
// Top level of the UTF-16 code unit to KOI8-R byte encoder.
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_koi8r_encoder_assert.svh"

// Converts one UTF-16 code unit per word into one KOI8-R byte. ASCII passes
// through, Cyrillic letters and a fixed set of box-drawing and symbol
// characters map to their KOI8-R codes, and anything else becomes a space.
// The block takes one word every clock cycle while it is not stalled, and each
// byte passes from the input register to the result register, with the table
// lookup between them. The result register lets a new word enter while a
// finished byte still waits, and back pressure on the output reaches the input
// only once both registers are full.
module utf16_to_koi8r_encoder (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [u2k_pkg::CODE_W-1:0]        s_axis_tdata,   // [15:0] code_unit
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [u2k_pkg::BYTE_W-1:0]        m_axis_tdata    // [7:0] koi8r_byte
);

    logic                        r_in_valid;
    logic                        n_in_valid;
    logic [u2k_pkg::CODE_W-1:0]  r_code;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [u2k_pkg::BYTE_W-1:0]  r_byte;
    logic                        out_free;
    logic                        in_free;
    logic                        in_take;

    assign out_free = !r_out_valid || m_axis_tready;
    assign in_free  = !r_in_valid || out_free;
    assign in_take  = s_axis_tvalid && in_free;

    assign s_axis_tready = in_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_byte;

    always_comb begin
        n_in_valid  = in_free ? s_axis_tvalid : r_in_valid;
        n_out_valid = out_free ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code <= s_axis_tdata;
        end
        if (out_free && r_in_valid) begin
            r_byte <= u2k_pkg::to_koi8r(r_code);
        end
    end

    `U2K_ASSERT_NEXT(a_take_fills_input, i_clk, i_rst_n, in_take, r_in_valid,
        "Accepted word did not reach the input register.")
    `U2K_ASSERT_NEXT(a_move_fills_output, i_clk, i_rst_n, r_in_valid && out_free,
        m_axis_tvalid, "Word in the input register did not reach the output.")
    `U2K_ASSERT_SAME(a_full_blocks_input, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !m_axis_tready, !s_axis_tready,
        "Input accepted while both registers were full and stalled.")
    `U2K_ASSERT_NEXT(a_ascii_passes, i_clk, i_rst_n,
        r_in_valid && out_free && (r_code <= u2k_pkg::ASCII_LAST),
        m_axis_tdata == $past(r_code[u2k_pkg::BYTE_W-1:0]),
        "ASCII code unit was not passed through unchanged.")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the UTF-16 to KOI8-R encoder with directed and random code units.
`timescale 1ns / 1ps

module tb_top;
    localparam int CODE_W = u2k_pkg::CODE_W;
    localparam int BYTE_W = u2k_pkg::BYTE_W;

    localparam int RANDOM_UNITS = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STEADY_FIRST = 1200;
    localparam int STEADY_LAST  = 1500;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [BYTE_W-1:0] SPACE = 8'h20;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] koi8;
        bit                known;
    } t_unit_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [CODE_W-1:0] s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;

    logic [BYTE_W-1:0] koi8_due[$];
    int                mismatch_count = 0;
    int                checked_count  = 0;
    int                sent_count     = 0;
    int                cycle_count    = 0;
    bit                steady         = 1'b0;

    const logic [BYTE_W-1:0] cyr_letters[64] = '{
        8'hE1, 8'hE2, 8'hF7, 8'hE7, 8'hE4, 8'hE5, 8'hF6, 8'hFA,
        8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF0,
        8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hE6, 8'hE8, 8'hE3, 8'hFE,
        8'hFB, 8'hFD, 8'hFF, 8'hF9, 8'hF8, 8'hFC, 8'hE0, 8'hF1,
        8'hC1, 8'hC2, 8'hD7, 8'hC7, 8'hC4, 8'hC5, 8'hD6, 8'hDA,
        8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0,
        8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hC6, 8'hC8, 8'hC3, 8'hDE,
        8'hDB, 8'hDD, 8'hDF, 8'hD9, 8'hD8, 8'hDC, 8'hC0, 8'hD1
    };

    const logic [CODE_W-1:0] box_symbols[64] = '{
        16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
        16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
        16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
        16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
        16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
        16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
        16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
        16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9
    };

    const t_unit_row directed_units[] = '{
        '{16'h0000, 8'h00, 1'b1}, '{16'h007F, 8'h7F, 1'b1}, '{16'h0041, 8'h41, 1'b1},
        '{16'h0080, SPACE, 1'b1}, '{16'hFFFF, SPACE, 1'b1}, '{16'h8000, SPACE, 1'b1},
        '{16'h0410, 8'hE1, 1'b1}, '{16'h042F, 8'hF1, 1'b1}, '{16'h0430, 8'hC1, 1'b1},
        '{16'h044F, 8'hD1, 1'b1}, '{16'h040F, SPACE, 1'b1}, '{16'h0450, SPACE, 1'b1},
        '{16'h2500, 8'h80, 1'b1}, '{16'h00A9, 8'hBF, 1'b1}, '{16'h0401, 8'hB3, 1'b1},
        '{16'h0451, 8'hA3, 1'b1}, '{16'hD800, SPACE, 1'b1}, '{16'hDFFF, SPACE, 1'b1},
        '{16'h00FF, SPACE, 1'b1}, '{16'h2501, SPACE, 1'b1}, '{16'h041F, 8'h00, 1'b0},
        '{16'h043C, 8'h00, 1'b0}, '{16'h2320, 8'h00, 1'b0}, '{16'h256C, 8'h00, 1'b0},
        '{16'h00F7, 8'h00, 1'b0}
    };

    utf16_to_koi8r_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] code_unit
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [7:0] koi8r_byte
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [BYTE_W-1:0] koi8_of(input logic [CODE_W-1:0] code);
        logic [BYTE_W-1:0] koi8;
        koi8 = SPACE;
        if (code <= 16'h007F) begin
            koi8 = code[BYTE_W-1:0];
        end else if (code >= 16'h0410 && code <= 16'h044F) begin
            koi8 = cyr_letters[6'(code - 16'h0410)];
        end else begin
            for (int k = 0; k < 64; k++) begin
                if (box_symbols[k] == code) begin
                    koi8 = 8'h80 + BYTE_W'(k);
                end
            end
        end
        return koi8;
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        int                pick;
        logic [CODE_W-1:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            code = CODE_W'($urandom_range(0, 16'h007F));
        end else if (pick < 45) begin
            code = CODE_W'($urandom_range(16'h040C, 16'h0453));
        end else if (pick < 70) begin
            code = box_symbols[$urandom_range(0, 63)];
        end else if (pick < 82) begin
            code = box_symbols[$urandom_range(0, 63)] ^ CODE_W'(1 << $urandom_range(0, 15));
        end else begin
            code = CODE_W'($urandom());
        end
        return code;
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        $display("ERROR at %0t: %s, got 0x%02h, expected 0x%02h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drives one code unit and waits until the encoder takes it.
    task automatic send_unit(input logic [CODE_W-1:0] code, input logic [BYTE_W-1:0] koi8);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 35) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = CODE_W'($urandom());
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = code;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        koi8_due.push_back(koi8);
        sent_count++;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready = steady || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d bytes outstanding",
                     cycle_count, koi8_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (koi8_due.size() == 0) begin
                report_mismatch("unexpected output word", m_axis_tdata, 8'h00);
            end else begin
                if (m_axis_tdata !== koi8_due[0]) begin
                    report_mismatch("koi8r_byte", m_axis_tdata, koi8_due[0]);
                end
                void'(koi8_due.pop_front());
                checked_count++;
            end
        end
    end

    initial begin
        logic [CODE_W-1:0] code;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_units[n]) begin
            send_unit(directed_units[n].code, directed_units[n].known ?
                      directed_units[n].koi8 : koi8_of(directed_units[n].code));
        end

        for (int n = 0; n < RANDOM_UNITS; n++) begin
            steady = (n >= STEADY_FIRST && n < STEADY_LAST);
            code   = random_code();
            send_unit(code, koi8_of(code));
        end
        steady = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        while (koi8_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d code units (%0d directed) covering ASCII, letters, symbols and gaps.",
                 sent_count, $size(directed_units));
        $display("Checked %0d KOI8-R bytes in %0d cycles.", checked_count, cycle_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/u2k_pkg.sv
design/utf16_to_koi8r_encoder.sv
sim/tb_top.sv
